// File: design/cbc_pkg.sv
// ----------------------------------------------------------------------------
// cbc_pkg
// Shared types and address map constants of the cartridge bank controller.
// ----------------------------------------------------------------------------
package cbc_pkg;

	// Result source codes
	typedef enum logic [1:0] {
		SRC_RAM  = 2'd0,
		SRC_ROM  = 2'd1,
		SRC_LOGO = 2'd2,
		SRC_NONE = 2'd3
	} src_t;

	// Address map
	localparam logic [15:0] ADDR_ROM_LO_WR = 16'h2000;
	localparam logic [15:0] ADDR_ROM_HI_WR = 16'h3000;
	localparam logic [15:0] ADDR_RAM_BANK  = 16'h4000;
	localparam logic [15:0] ADDR_MODE      = 16'h6000;
	localparam logic [15:0] ADDR_CTRL_END  = 16'h8000;
	localparam logic [15:0] ADDR_RAM_LO    = 16'hA000;
	localparam logic [15:0] ADDR_RAM_END   = 16'hC000;
	localparam logic [15:0] ADDR_LOGO_LO   = 16'h0104;
	localparam logic [15:0] ADDR_LOGO_LAST = 16'h0133;
	localparam logic [15:0] ADDR_FIXED_END = 16'h4000;

	localparam int unsigned BANK_ADDR_BITS = 13;
	localparam int unsigned ROM_BANK_MAX   = 9;
	localparam logic [7:0]  SAVE_BYTE0     = 8'hFF;

	// Decoded access, handed from the register block to the pipeline
	typedef struct packed {
		src_t        source;
		logic [22:0] rom_offset;
		logic [13:0] logo_index;
	} cbc_dec_t;

endpackage

// File: design/cbc_if.sv
// ----------------------------------------------------------------------------
// cbc_req_if / cbc_rsp_if
// Valid/ready channels for bus requests and their results.
// ----------------------------------------------------------------------------
interface cbc_req_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [15:0] bus_address;
	logic [7:0]  write_byte;

	modport source (output valid, output op, output bus_address, output write_byte,
		input ready);
	modport sink (input valid, input op, input bus_address, input write_byte,
		output ready);
endinterface

interface cbc_rsp_if;
	logic             valid;
	logic             ready;
	cbc_pkg::src_t    src_code;
	logic [7:0]       read_byte;
	logic [22:0]      rom_offset;
	logic [13:0]      logo_index;

	modport source (output valid, output src_code, output read_byte, output rom_offset,
		output logo_index, input ready);
	modport sink (input valid, input src_code, input read_byte, input rom_offset,
		input logo_index, output ready);
endinterface

// File: design/cartridge_bank_controller_core.sv
// ----------------------------------------------------------------------------
// cartridge_bank_controller_core
// Cartridge bus bank controller: bank registers, banked save RAM and
// result pipeline.
// ----------------------------------------------------------------------------
// One request is taken per clock unless the output register is stalled or
// the clearing pass runs; its result passes through stage 1 (the registered
// save RAM read) and then the output register. Results wait in the output
// register while the next request is read from RAM. After reset a clearing
// pass writes the whole save RAM, 0x2000 << RAM_BANK_BITS bytes (32768 at
// the default), and no request is taken until it ends.
module cartridge_bank_controller_core #(
	parameter int unsigned RAM_BANK_BITS = 2,
	parameter int unsigned ROM_BANK_BITS = 9
) (
	input  logic       clk,
	input  logic       arst_n,
	cbc_req_if.sink    req,
	cbc_rsp_if.source  rsp
);
	import cbc_pkg::*;

	localparam int unsigned RAM_AW = BANK_ADDR_BITS + RAM_BANK_BITS;

	cbc_dec_t          dec;
	logic              ram_we;
	logic [RAM_AW-1:0] ram_addr;
	logic [7:0]        ram_rdata;
	logic              ram_ready;
	logic              accept;
	logic              advance;

	logic              valid_s1;
	cbc_dec_t          dec_s1;
	logic              valid_q;
	cbc_dec_t          dec_q;
	logic [7:0]        byte_q;

	// Move stage 1 into the output register when it is empty or being taken
	assign advance   = valid_s1 && (!valid_q || rsp.ready);
	assign req.ready = ram_ready && (!valid_s1 || advance);
	assign accept    = req.valid && req.ready;

	cbc_bank_regs #(
		.RAM_BANK_BITS (RAM_BANK_BITS),
		.ROM_BANK_BITS (ROM_BANK_BITS),
		.RAM_AW        (RAM_AW)
	) u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.op          (req.op),
		.bus_address (req.bus_address),
		.write_byte  (req.write_byte),
		.dec         (dec),
		.ram_we      (ram_we),
		.ram_addr    (ram_addr)
	);

	cbc_save_ram #(
		.RAM_AW (RAM_AW)
	) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (accept),
		.we     (ram_we),
		.addr   (ram_addr),
		.wdata  (req.write_byte),
		.rdata  (ram_rdata),
		.ready  (ram_ready)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				valid_q <= 1'b1;
			else if (rsp.ready)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			dec_s1 <= dec;
		if (advance) begin
			dec_q  <= dec_s1;
			byte_q <= (dec_s1.source == SRC_RAM) ? ram_rdata : 8'd0;
		end
	end

	assign rsp.valid      = valid_q;
	assign rsp.src_code   = dec_q.source;
	assign rsp.read_byte  = byte_q;
	assign rsp.rom_offset = dec_q.rom_offset;
	assign rsp.logo_index = dec_q.logo_index;

endmodule

// File: design/cbc_bank_regs.sv
// ----------------------------------------------------------------------------
// cbc_bank_regs
// Bank, mode and logo registers; decodes each request into its result
// fields and the save RAM address.
// ----------------------------------------------------------------------------
module cbc_bank_regs #(
	parameter int unsigned RAM_BANK_BITS = 2,
	parameter int unsigned ROM_BANK_BITS = 9,
	parameter int unsigned RAM_AW        = 15
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic                  op,
	input  logic [15:0]           bus_address,
	input  logic [7:0]            write_byte,
	output cbc_pkg::cbc_dec_t     dec,
	output logic                  ram_we,
	output logic [RAM_AW-1:0]     ram_addr
);
	import cbc_pkg::*;

	localparam int unsigned RBW = (RAM_BANK_BITS > 0) ? RAM_BANK_BITS : 1;
	localparam int unsigned SUM_W = BANK_ADDR_BITS + 4;
	localparam logic [1:0] RAM_MASK = (RAM_BANK_BITS >= 2) ? 2'b11 :
		2'((1 << RAM_BANK_BITS) - 1);

	logic [ROM_BANK_BITS-1:0] rom_sel_q;
	logic [RBW-1:0]           ram_sel_q;
	logic                     mode_q;
	logic                     logo_done_q;

	logic [ROM_BANK_MAX-1:0]  rom9;
	logic [ROM_BANK_MAX-1:0]  rom_lo_w;
	logic [ROM_BANK_MAX-1:0]  rom_hi_w;
	logic [SUM_W-1:0]         ram_sum;
	logic                     in_ram;
	logic                     wr;

	assign rom9     = ROM_BANK_MAX'(rom_sel_q);
	assign rom_lo_w = {1'b0, write_byte};
	assign rom_hi_w = {(write_byte != 8'd0), rom9[7:0]};
	assign in_ram   = (bus_address >= ADDR_RAM_LO) && (bus_address < ADDR_RAM_END);
	assign wr       = accept && op;
	assign ram_sum  = (SUM_W'(ram_sel_q) << BANK_ADDR_BITS) |
		SUM_W'(bus_address[BANK_ADDR_BITS-1:0]);
	assign ram_addr = ram_sum[RAM_AW-1:0];
	assign ram_we   = wr && in_ram;

	always_comb begin
		dec.source     = SRC_NONE;
		dec.rom_offset = '0;
		dec.logo_index = '0;
		if (!op) begin
			if (bus_address < ADDR_LOGO_LO) begin
				dec.source     = SRC_ROM;
				dec.rom_offset = 23'(bus_address);
			end else if (bus_address < ADDR_FIXED_END) begin
				if (logo_done_q) begin
					dec.source     = SRC_ROM;
					dec.rom_offset = 23'(bus_address);
				end else begin
					dec.source     = SRC_LOGO;
					dec.logo_index = 14'(bus_address - ADDR_LOGO_LO);
				end
			end else if (bus_address < ADDR_CTRL_END) begin
				dec.source     = SRC_ROM;
				dec.rom_offset = {rom9, bus_address[13:0]};
			end else if (in_ram) begin
				dec.source = SRC_RAM;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_sel_q   <= ROM_BANK_BITS'(1);
			ram_sel_q   <= '0;
			mode_q      <= 1'b0;
			logo_done_q <= 1'b0;
		end else begin
			if (wr) begin
				priority if (bus_address < ADDR_ROM_LO_WR) begin
					// RAM enable range: nothing to hold
				end else if (bus_address < ADDR_ROM_HI_WR) begin
					rom_sel_q <= rom_lo_w[ROM_BANK_BITS-1:0];
				end else if (bus_address < ADDR_RAM_BANK) begin
					rom_sel_q <= rom_hi_w[ROM_BANK_BITS-1:0];
				end else if (bus_address < ADDR_MODE) begin
					if (!mode_q)
						ram_sel_q <= RBW'(write_byte[1:0] & RAM_MASK);
				end else if (bus_address < ADDR_CTRL_END) begin
					mode_q <= (write_byte != 8'd0);
				end else begin
					// RAM data or unmapped: no register change
				end
			end
			if (accept && !op && !logo_done_q && bus_address == ADDR_LOGO_LAST)
				logo_done_q <= 1'b1;
		end
	end

endmodule

// File: design/cbc_save_ram.sv
// ----------------------------------------------------------------------------
// cbc_save_ram
// Banked save RAM with a registered read and a clearing pass after
// reset that loads byte 0 with FF and every other byte with zero.
// ----------------------------------------------------------------------------
module cbc_save_ram #(
	parameter int unsigned RAM_AW = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              re,
	input  logic              we,
	input  logic [RAM_AW-1:0] addr,
	input  logic [7:0]        wdata,
	output logic [7:0]        rdata,
	output logic              ready
);
	import cbc_pkg::*;

	localparam int unsigned DEPTH = 1 << RAM_AW;

	logic [7:0]        mem [DEPTH];
	logic [RAM_AW-1:0] clr_addr_q;
	logic              clr_busy_q;

	assign ready = !clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + RAM_AW'(1);
			if (&clr_addr_q)
				clr_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q)
			mem[clr_addr_q] <= (clr_addr_q == '0) ? SAVE_BYTE0 : 8'd0;
		else if (we)
			mem[addr] <= wdata;
		if (re)
			rdata <= mem[addr];
	end

endmodule
